// ===== hw/rtl/tfs_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none

package tfs_pkg;

    // Configuration register indexes
    localparam logic [1:0] CFG_ENABLE      = 2'd0;
    localparam logic [1:0] CFG_SPEEDS      = 2'd1;
    localparam logic [1:0] CFG_THRESHOLDS  = 2'd2;

    localparam int CFG_ADDR_W = 2;
    localparam int CFG_DATA_W = 64;

    // Reset values and fixed speeds
    localparam logic [63:0] SPEEDS_RST      = 64'hFFA0_7870_6860_544D;
    localparam logic [47:0] THRESHOLDS_RST  = 48'h504B_4846_443E;
    localparam logic [7:0]  RELEASE_SPEED   = 8'h5F;
    localparam logic [7:0]  SPEED_RST       = 8'h33;
    localparam logic [2:0]  ALIVE_PERIOD    = 3'd5;

    // LED levels
    localparam logic [1:0] LED_ALIVE = 2'd0;
    localparam logic [1:0] LED_COOL  = 2'd1;
    localparam logic [1:0] LED_WARM  = 2'd2;
    localparam logic [1:0] LED_HOT   = 2'd3;

    // Live configuration seen by the datapath
    typedef struct packed {
        logic        enable;
        logic [63:0] speeds;
        logic [47:0] thresholds;
    } t_cfg;

    // One result item
    typedef struct packed {
        logic       stopped;
        logic [1:0] led_level;
        logic       led_write;
        logic       fan_release;
        logic [7:0] fan_speed;
        logic       fan_write;
    } t_result;

    localparam int OUT_DATA_W = 16;

    function automatic logic [7:0] speed_entry(input logic [63:0] tbl, input logic [2:0] k);
        speed_entry = tbl[{k, 3'b000} +: 8];
    endfunction

    function automatic logic [7:0] thr_entry(input logic [47:0] thr, input logic [2:0] k);
        thr_entry = thr[{k, 3'b000} +: 8];
    endfunction

endpackage

`default_nettype wire

// ===== hw/rtl/tfs_core.sv =====
`timescale 1ns / 1ps
`default_nettype none

module tfs_core (
    input  wire logic           i_clk,
    input  wire logic           i_rst_n,
    input  wire tfs_pkg::t_cfg  i_cfg,
    input  wire logic           i_rearm,     // enable written to 0
    input  wire logic           i_step,      // one item processed this cycle
    input  wire logic [7:0]     i_sample_temp,
    input  wire logic           i_read_ok,
    output tfs_pkg::t_result    o_result
);
    import tfs_pkg::*;

    logic       r_toggle, n_toggle;
    logic [7:0] r_cpu, n_cpu;
    logic [7:0] r_gpu, n_gpu;
    logic       r_rising, n_rising;
    logic [7:0] r_speed, n_speed;
    logic [1:0] r_led, n_led;
    logic [2:0] r_alive, n_alive;
    logic       r_rel_done, n_rel_done;

    logic [7:0] temp_in;
    logic [7:0] temp_max;
    logic [5:0] ge;
    logic [7:0] speed_sel;
    logic [1:0] level;
    logic [2:0] alive_dec;
    logic       rising_mid;

    // Per-item update of the fan state
    always_comb begin
        n_toggle   = r_toggle;
        n_cpu      = r_cpu;
        n_gpu      = r_gpu;
        n_rising   = r_rising;
        n_speed    = r_speed;
        n_led      = r_led;
        n_alive    = r_alive;
        n_rel_done = r_rel_done;
        o_result   = '0;

        temp_in = i_read_ok ? i_sample_temp : 8'd0;
        if (!r_toggle) begin
            n_cpu = temp_in;
        end else begin
            n_gpu = temp_in;
        end
        temp_max = (n_gpu > n_cpu) ? n_gpu : n_cpu;

        for (int k = 0; k < 6; k++) begin
            ge[k] = (temp_max >= thr_entry(i_cfg.thresholds, 3'(k)));
        end
        rising_mid = r_rising | ge[1];

        // Threshold ladder, highest first
        speed_sel = speed_entry(i_cfg.speeds, 3'd0);
        priority if (ge[5]) speed_sel = speed_entry(i_cfg.speeds, 3'd7);
        else if (ge[4])     speed_sel = speed_entry(i_cfg.speeds, 3'd6);
        else if (ge[3])     speed_sel = speed_entry(i_cfg.speeds, 3'd5);
        else if (ge[2])     speed_sel = speed_entry(i_cfg.speeds, 3'd4);
        else if (ge[1])     speed_sel = speed_entry(i_cfg.speeds, 3'd3);
        else if (ge[0])     speed_sel = speed_entry(i_cfg.speeds,
                                                    rising_mid ? 3'd2 : 3'd1);
        else                speed_sel = speed_entry(i_cfg.speeds, 3'd0);

        priority if (ge[4]) level = LED_HOT;
        else if (ge[2])     level = LED_WARM;
        else                level = LED_COOL;

        alive_dec = r_alive - 3'd1;

        if (i_cfg.enable) begin
            n_toggle = ~r_toggle;
            // Flag clears only when the reading falls below every threshold
            n_rising = (|ge) ? rising_mid : 1'b0;
            if (speed_sel != r_speed) begin
                o_result.fan_write = 1'b1;
                o_result.fan_speed = speed_sel;
            end
            n_speed = speed_sel;
            n_alive = alive_dec;
            // Alive refresh: blink LED and clear the held speed so a nonzero speed is commanded again
            if (alive_dec == 3'd0) begin
                level   = LED_ALIVE;
                n_alive = ALIVE_PERIOD;
                n_speed = 8'd0;
            end
            if (level != r_led) begin
                o_result.led_write = 1'b1;
                o_result.led_level = level;
                n_led              = level;
            end
        end else begin
            n_cpu = r_cpu;
            n_gpu = r_gpu;
            if (!r_rel_done) begin
                o_result.fan_release = 1'b1;
                o_result.fan_speed   = RELEASE_SPEED;
                n_rel_done           = 1'b1;
            end
            o_result.stopped = 1'b1;
        end
    end

    // State registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_toggle   <= 1'b0;
            r_cpu      <= 8'd0;
            r_gpu      <= 8'd0;
            r_rising   <= 1'b0;
            r_speed    <= SPEED_RST;
            r_led      <= LED_ALIVE;
            r_alive    <= ALIVE_PERIOD;
            r_rel_done <= 1'b0;
        end else if (i_rearm) begin
            r_rel_done <= 1'b0;
        end else if (i_step) begin
            r_toggle   <= n_toggle;
            r_cpu      <= n_cpu;
            r_gpu      <= n_gpu;
            r_rising   <= n_rising;
            r_speed    <= n_speed;
            r_led      <= n_led;
            r_alive    <= n_alive;
            r_rel_done <= n_rel_done;
        end
    end

    // Alive counter never leaves 1..5
    a_alive_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_alive != 3'd0) && (r_alive <= ALIVE_PERIOD))
        else $error("alive counter out of range");

    // A step with automatic control never both releases and commands
    a_no_mixed: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_step |-> !(o_result.fan_write && o_result.fan_release))
        else $error("fan command and release in one item");

    // Disabled steps leave the held temperatures alone
    a_hold_temps: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_step && !i_cfg.enable && !i_rearm) |=> ($stable(r_cpu) && $stable(r_gpu)))
        else $error("held temperature changed while disabled");

endmodule

`default_nettype wire

// ===== hw/rtl/thermal_fan_speed_selector_top.sv =====
`timescale 1ns / 1ps
`default_nettype none

// Channel   Direction  Handshake                      Payload
// s_axis    in         s_axis_tvalid / s_axis_tready  tdata: sample_temp; tuser: read_ok
// m_axis    out        m_axis_tvalid / m_axis_tready  tdata: fan fields, led fields, stopped
// cfg       in         i_cfg_we (no wait)             i_cfg_addr, i_cfg_wdata
//
// One item per cycle unless m_axis_tready stalls; path: input register, result register.
// The ladder, speed compare and LED level resolve combinationally between the two registers.
// A stalled result holds in the result register while the next item waits in the
// input register; s_axis_tready drops only when both are full.
// Reset (synchronous, active low) loads the default tables and the state of the fan logic.
module thermal_fan_speed_selector_top (
    input  wire logic                               i_clk,
    input  wire logic                               i_rst_n,
    // Input items
    input  wire logic                               s_axis_tvalid,
    output logic                                    s_axis_tready,
    input  wire logic [7:0]                         s_axis_tdata,  // [7:0] sample_temp
    input  wire logic                               s_axis_tuser,  // [0] read_ok
    // Result items
    output logic                                    m_axis_tvalid,
    input  wire logic                               m_axis_tready,
    // [0] fan_write, [8:1] fan_speed, [9] fan_release, [10] led_write,
    // [12:11] led_level, [13] stopped, [15:14] zero
    output logic [tfs_pkg::OUT_DATA_W-1:0]          m_axis_tdata,
    // Configuration writes
    input  wire logic                               i_cfg_we,
    input  wire logic [tfs_pkg::CFG_ADDR_W-1:0]     i_cfg_addr,
    input  wire logic [tfs_pkg::CFG_DATA_W-1:0]     i_cfg_wdata
);
    import tfs_pkg::*;

    t_cfg       r_cfg;
    logic       r_in_valid;
    logic [7:0] r_in_temp;
    logic       r_in_ok;
    logic       r_out_valid;
    t_result    r_out;
    t_result    core_result;
    logic       advance;
    logic       rearm;

    // Configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.enable      <= 1'b1;
            r_cfg.speeds      <= SPEEDS_RST;
            r_cfg.thresholds  <= THRESHOLDS_RST;
        end else if (i_cfg_we) begin
            unique case (i_cfg_addr)
                CFG_ENABLE:      r_cfg.enable      <= i_cfg_wdata[0];
                CFG_SPEEDS:      r_cfg.speeds      <= i_cfg_wdata;
                CFG_THRESHOLDS:  r_cfg.thresholds  <= i_cfg_wdata[47:0];
                default: ;
            endcase
        end
    end

    assign rearm = i_cfg_we && (i_cfg_addr == CFG_ENABLE) && !i_cfg_wdata[0];

    // Pipeline control
    assign advance       = r_in_valid && (!r_out_valid || m_axis_tready);
    assign s_axis_tready = !r_in_valid || advance;

    // Input register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (s_axis_tready) begin
            r_in_valid <= s_axis_tvalid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s_axis_tvalid && s_axis_tready) begin
            r_in_temp <= s_axis_tdata;
            r_in_ok   <= s_axis_tuser;
        end
    end

    tfs_core u_core (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg         (r_cfg),
        .i_rearm       (rearm),
        .i_step        (advance),
        .i_sample_temp (r_in_temp),
        .i_read_ok     (r_in_ok),
        .o_result      (core_result)
    );

    // Result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (advance) begin
            r_out_valid <= 1'b1;
        end else if (m_axis_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (advance) begin
            r_out <= core_result;
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = {2'b00, r_out};

    // A stalled result is never overwritten
    a_no_overwrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && !m_axis_tready) |-> !advance)
        else $error("result overwritten while stalled");

    // A full input register that cannot move blocks the input side
    a_in_block: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_in_valid && !advance) |-> !s_axis_tready)
        else $error("input accepted over a waiting item");

    // A release always carries the release speed
    a_release_speed: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_out.fan_release) |-> (r_out.fan_speed == RELEASE_SPEED))
        else $error("release without release speed");

endmodule

`default_nettype wire

// ===== tb/thermal_fan_speed_selector_top_tb.sv =====
`timescale 1ns / 1ps

module thermal_fan_speed_selector_top_tb;
    import tfs_pkg::*;

    // Index past the end of the register list; writes to it must do nothing
    localparam logic [1:0] CFG_UNUSED = 2'd3;
    localparam int HOLD_CYCLES = 40;
    localparam int PHASE_ITEMS = 72;
    localparam int NUM_PHASES  = 10;
    localparam int DISABLED_ITEMS = 10;

    // Tracks the fan logic state, predicts the command item for every reading
    // and checks the items coming out of the block in order
    class fan_cmd_tracker;
        bit        en;
        bit [63:0] speed_tbl;
        bit [47:0] thr;
        bit        toggle;
        bit [7:0]  proc_temp;
        bit [7:0]  gpu_temp;
        bit        rising;
        bit [7:0]  cur_speed;
        bit [1:0]  shown_led;
        bit [2:0]  alive;
        bit        released;
        t_result   pending_cmds[$];
        int        mismatches;

        function new();
            en         = 1'b1;
            speed_tbl  = SPEEDS_RST;
            thr        = THRESHOLDS_RST;
            toggle     = 1'b0;
            proc_temp  = 8'd0;
            gpu_temp   = 8'd0;
            rising     = 1'b0;
            cur_speed  = SPEED_RST;
            shown_led  = LED_ALIVE;
            alive      = ALIVE_PERIOD;
            released   = 1'b0;
            mismatches = 0;
        endfunction

        function void write_reg(bit [1:0] addr, bit [63:0] data);
            case (addr)
                CFG_ENABLE: begin
                    en = data[0];
                    // disabling re-arms the one-shot release
                    if (!data[0])
                        released = 1'b0;
                end
                CFG_SPEEDS:      speed_tbl = data;
                CFG_THRESHOLDS:  thr = data[47:0];
                default: ;
            endcase
        endfunction

        function bit [7:0] tbl_entry(int k);
            return speed_tbl[8*k +: 8];
        endfunction

        function bit [7:0] thr_at(int k);
            return thr[8*k +: 8];
        endfunction

        function void log_reading(bit [7:0] temp, bit ok);
            t_result   exp_cmd;
            bit [7:0]  hot;
            bit [7:0]  spd;
            bit [1:0]  lvl;
            exp_cmd = '0;
            if (en) begin
                // store the sensor due this step, failed read counts as zero
                if (!toggle)
                    proc_temp = ok ? temp : 8'd0;
                else
                    gpu_temp = ok ? temp : 8'd0;
                toggle = ~toggle;
                hot = (gpu_temp > proc_temp) ? gpu_temp : proc_temp;

                // speed ladder, top threshold first; lowest band has hysteresis
                if (hot >= thr_at(1))
                    rising = 1'b1;
                if (hot >= thr_at(5))
                    spd = tbl_entry(7);
                else if (hot >= thr_at(4))
                    spd = tbl_entry(6);
                else if (hot >= thr_at(3))
                    spd = tbl_entry(5);
                else if (hot >= thr_at(2))
                    spd = tbl_entry(4);
                else if (hot >= thr_at(1))
                    spd = tbl_entry(3);
                else if (hot >= thr_at(0))
                    spd = tbl_entry(rising ? 2 : 1);
                else begin
                    spd = tbl_entry(0);
                    rising = 1'b0;
                end
                if (spd != cur_speed) begin
                    exp_cmd.fan_write = 1'b1;
                    exp_cmd.fan_speed = spd;
                    cur_speed = spd;
                end

                if (hot >= thr_at(4))
                    lvl = LED_HOT;
                else if (hot >= thr_at(2))
                    lvl = LED_WARM;
                else
                    lvl = LED_COOL;

                // alive tick: blink LED and clear the held speed so a nonzero speed is re-sent next step
                alive = alive - 3'd1;
                if (alive == 3'd0) begin
                    lvl = LED_ALIVE;
                    alive = ALIVE_PERIOD;
                    cur_speed = 8'd0;
                end
                if (lvl != shown_led) begin
                    exp_cmd.led_write = 1'b1;
                    exp_cmd.led_level = lvl;
                    shown_led = lvl;
                end
            end else begin
                if (!released) begin
                    exp_cmd.fan_release = 1'b1;
                    exp_cmd.fan_speed = RELEASE_SPEED;
                    released = 1'b1;
                end
                exp_cmd.stopped = 1'b1;
            end
            pending_cmds.push_back(exp_cmd);
        endfunction

        function void cmp(string name, int want, int got);
            if (want != got) begin
                $error("%s: expected 0x%0h, got 0x%0h", name, want, got);
                mismatches++;
            end
        endfunction

        function void check_command(bit [15:0] data);
            t_result want;
            t_result got;
            got = t_result'(data[13:0]);
            if (pending_cmds.size() == 0) begin
                $error("result item 0x%0h with nothing expected", data);
                mismatches++;
                return;
            end
            want = pending_cmds.pop_front();
            cmp("fan_write", want.fan_write, got.fan_write);
            cmp("fan_speed", want.fan_speed, got.fan_speed);
            cmp("fan_release", want.fan_release, got.fan_release);
            cmp("led_write", want.led_write, got.led_write);
            cmp("led_level", want.led_level, got.led_level);
            cmp("stopped", want.stopped, got.stopped);
            cmp("pad", 0, data[15:14]);
        endfunction

        function int pending();
            return pending_cmds.size();
        endfunction
    endclass

    logic        i_clk;
    logic        i_rst_n;
    logic        s_axis_tvalid;
    logic        s_axis_tready;
    logic [7:0]  s_axis_tdata;   // [7:0] sample_temp
    logic        s_axis_tuser;   // [0] read_ok
    logic        m_axis_tvalid;
    logic        m_axis_tready;
    // [0] fan_write, [8:1] fan_speed, [9] fan_release, [10] led_write,
    // [12:11] led_level, [13] stopped, [15:14] zero
    logic [15:0] m_axis_tdata;
    logic        i_cfg_we;
    logic [1:0]  i_cfg_addr;
    logic [63:0] i_cfg_wdata;

    fan_cmd_tracker trk;
    bit tx_idle_on = 1'b1;
    bit rx_idle_on = 1'b1;
    bit hold_req = 1'b0;

    thermal_fan_speed_selector_top dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_addr    (i_cfg_addr),
        .i_cfg_wdata   (i_cfg_wdata)
    );

    // Clock
    initial begin
        i_clk = 1'b0;
        forever #10 i_clk = ~i_clk;
    end

    // Run limit
    initial begin
        #5_000_000;
        $display("RESULT: ERROR");
        $finish;
    end

    // Both handshakes sampled at the rising edge
    always @(posedge i_clk) begin
        if (i_rst_n && s_axis_tvalid && s_axis_tready)
            trk.log_reading(s_axis_tdata, s_axis_tuser);
        if (i_rst_n && m_axis_tvalid && m_axis_tready)
            trk.check_command(m_axis_tdata);
    end

    // Receiver: random stall bursts, plus one long hold on request
    initial begin
        m_axis_tready = 1'b0;
        forever begin
            @(negedge i_clk);
            if (hold_req) begin
                hold_req = 1'b0;
                m_axis_tready = 1'b0;
                repeat (HOLD_CYCLES - 1) @(negedge i_clk);
            end else if (rx_idle_on && $urandom_range(0, 9) == 0) begin
                m_axis_tready = 1'b0;
                repeat ($urandom_range(0, 6)) @(negedge i_clk);
            end else begin
                m_axis_tready = 1'b1;
            end
        end
    end

    task automatic send_reading(input bit [7:0] temp, input bit ok);
        // optional idle burst before the item
        if (tx_idle_on && $urandom_range(0, 7) == 0) begin
            @(negedge i_clk);
            s_axis_tvalid = 1'b0;
            repeat ($urandom_range(0, 6)) @(negedge i_clk);
        end
        @(negedge i_clk);
        s_axis_tvalid = 1'b1;
        s_axis_tdata  = temp;
        s_axis_tuser  = ok;
        do @(posedge i_clk); while (!s_axis_tready);
    endtask

    // Stop offering and wait for every outstanding command item
    task automatic settle();
        @(negedge i_clk);
        s_axis_tvalid = 1'b0;
        while (trk.pending() != 0)
            @(posedge i_clk);
        repeat (4) @(posedge i_clk);
    endtask

    task automatic cfg_write(input logic [1:0] addr, input logic [63:0] data);
        @(negedge i_clk);
        i_cfg_we    = 1'b1;
        i_cfg_addr  = addr;
        i_cfg_wdata = data;
        trk.write_reg(addr, data);
        @(negedge i_clk);
        i_cfg_we = 1'b0;
    endtask

    // Mostly near a threshold so the ladder edges get hit, sometimes anywhere
    function automatic bit [7:0] pick_temp();
        int v;
        if ($urandom_range(0, 9) < 7) begin
            v = int'(trk.thr_at($urandom_range(0, 5))) + $urandom_range(0, 6) - 3;
            if (v < 0)
                v = 0;
            if (v > 255)
                v = 255;
            return v[7:0];
        end
        return 8'($urandom_range(0, 255));
    endfunction

    function automatic bit [47:0] ascending_thr();
        bit [47:0] v;
        int t;
        t = $urandom_range(20, 120);
        for (int k = 0; k < 6; k++) begin
            v[8*k +: 8] = t[7:0];
            t = t + $urandom_range(0, 10);
            if (t > 255)
                t = 255;
        end
        return v;
    endfunction

    // Threshold write with junk in the bits above the register width
    task automatic write_thr(input bit [47:0] thr);
        cfg_write(CFG_THRESHOLDS, {16'($urandom), thr});
    endtask

    task automatic run_phase(input int n_items, input int hold_at, input int pause_at);
        for (int i = 0; i < n_items; i++) begin
            if (i == hold_at)
                hold_req = 1'b1;
            if (i == pause_at) begin
                @(negedge i_clk);
                s_axis_tvalid = 1'b0;
                while (trk.pending() != 0)
                    @(posedge i_clk);
            end
            send_reading(pick_temp(), $urandom_range(0, 9) != 0);
        end
    endtask

    initial begin
        i_rst_n       = 1'b0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata  = 8'd0;
        s_axis_tuser  = 1'b0;
        i_cfg_we      = 1'b0;
        i_cfg_addr    = CFG_ENABLE;
        i_cfg_wdata   = 64'd0;
        trk = new();
        repeat (3) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        // Directed: field extremes, failed reads, ladder walk with hysteresis
        send_reading(8'd0, 1'b1);
        send_reading(8'd255, 1'b1);
        send_reading(8'd255, 1'b0);
        send_reading(8'd0, 1'b0);
        send_reading(8'd62, 1'b1);
        send_reading(8'd0, 1'b1);
        send_reading(8'd68, 1'b1);
        send_reading(8'd0, 1'b1);
        send_reading(8'd64, 1'b1);
        send_reading(8'd64, 1'b1);
        send_reading(8'd61, 1'b1);
        send_reading(8'd61, 1'b1);
        send_reading(8'd63, 1'b1);
        send_reading(8'd75, 1'b1);
        send_reading(8'd80, 1'b1);
        send_reading(8'd200, 1'b0);
        settle();

        // Release once per disabled period; re-disable re-arms, re-enable does not
        cfg_write(CFG_ENABLE, 64'd0);
        send_reading(8'd90, 1'b1);
        send_reading(8'd90, 1'b1);
        settle();
        cfg_write(CFG_ENABLE, 64'd0);
        send_reading(8'd40, 1'b1);
        settle();
        cfg_write(CFG_ENABLE, 64'd1);
        send_reading(8'd70, 1'b1);
        send_reading(8'd45, 1'b1);
        settle();
        cfg_write(CFG_UNUSED, {$urandom, $urandom});
        cfg_write(CFG_ENABLE, 64'd1);
        send_reading(8'd72, 1'b1);
        settle();
        cfg_write(CFG_ENABLE, 64'd0);
        send_reading(8'd72, 1'b1);
        settle();

        // Random phases, each under its own register setting
        for (int ph = 0; ph < NUM_PHASES; ph++) begin
            if (ph >= NUM_PHASES - 2) begin
                tx_idle_on = 1'b0;
                rx_idle_on = 1'b0;
            end
            cfg_write(CFG_ENABLE, (ph == 4) ? 64'd0 : 64'd1);
            case (ph)
                1: begin
                    cfg_write(CFG_SPEEDS, 64'hFFFF_FFFF_FFFF_FFFF);
                    write_thr(48'd0);
                end
                2: begin
                    // zero speed table: no command after an alive reload
                    cfg_write(CFG_SPEEDS, 64'd0);
                    write_thr(48'hFFFF_FFFF_FFFF);
                end
                3: begin
                    // unordered thresholds
                    cfg_write(CFG_SPEEDS, {$urandom, $urandom});
                    write_thr({16'($urandom), $urandom});
                end
                4, 5: begin
                    cfg_write(CFG_SPEEDS, (ph == 4) ? {$urandom, $urandom}
                                                    : SPEEDS_RST);
                    write_thr(THRESHOLDS_RST);
                end
                default: begin
                    cfg_write(CFG_SPEEDS, {$urandom, $urandom});
                    write_thr(ascending_thr());
                end
            endcase
            run_phase((ph == 4) ? DISABLED_ITEMS : PHASE_ITEMS,
                      (ph == 2) ? 20 : -1, (ph == 3) ? 30 : -1);
            settle();
        end

        repeat (6) @(posedge i_clk);
        if (trk.mismatches == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end

endmodule
